>>> hdl/hslc_pkg.sv
// shared constants, types and the channel rounding function for the colormap
`default_nettype none

package hslc_pkg;

  // number formats
  localparam int FRAC_BITS  = 16;
  localparam int COLOR_BITS = 8;
  localparam int DATA_W     = 32;
  localparam int QUOT_BITS  = FRAC_BITS + 1;
  localparam int DIVD_W     = DATA_W + FRAC_BITS + 1;
  localparam int CHAN_IN_W  = 2 * FRAC_BITS + 1;
  localparam int CHAN_ACC_W = CHAN_IN_W + COLOR_BITS;

  // t = 1.0 in Q1.FRAC_BITS
  localparam logic [FRAC_BITS:0] T_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  // configuration register indexes
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH = CFG_IDX_W'(1);

  // register reset values, -1.0 and +1.0 in Q15.16
  localparam logic [DATA_W-1:0] RANGE_LOW_RST  = 32'hFFFF_0000;
  localparam logic [DATA_W-1:0] RANGE_HIGH_RST = 32'h0001_0000;

  // rounding constants for the channel scaling
  localparam logic [CHAN_ACC_W-1:0] CH_MAX  = CHAN_ACC_W'((1 << COLOR_BITS) - 1);
  localparam logic [CHAN_ACC_W-1:0] CH_HALF = CHAN_ACC_W'(1) << (2 * FRAC_BITS - 1);

  // word handed from one divider cell to the next
  typedef struct packed {
    logic [DATA_W-1:0]    rem;
    logic [QUOT_BITS-1:0] dbits;
    logic [QUOT_BITS-1:0] quot;
    logic [DATA_W-1:0]    den;
    logic                 clamp_lo;
    logic                 clamp_hi;
    logic                 invalid;
  } div_word_t;

  // scale a Q1.(2*FRAC_BITS) component to COLOR_BITS, rounded to nearest
  function automatic logic [COLOR_BITS-1:0] to_channel(input logic [CHAN_IN_W-1:0] p);
    logic [CHAN_ACC_W-1:0] acc;
    acc = {{COLOR_BITS{1'b0}}, p} * CH_MAX + CH_HALF;
    return acc[2*FRAC_BITS +: COLOR_BITS];
  endfunction

endpackage

`default_nettype wire

>>> hdl/value_to_hsl_rgb_colormap.sv
// Scalar to RGB colormap through HSL. Takes one signed Q15.16 sample per word and
// returns one 8-bit RGB colour per word, one word per clock when the output is not
// stalled. Words pass through the range arithmetic registers, a chain of 17 divider
// cells that each resolve one quotient bit of the normalized fraction, and the hue
// product and channel rounding registers. Each stage holds its word while the next is
// full and stalled, so the input keeps flowing into empty stages while a result waits
// at the output. range_low and range_high may only be written while no word is in
// flight; a write with any other index is dropped.
`default_nettype none

module value_to_hsl_rgb_colormap (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] sample_value
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [7:0] red, [15:8] green, [23:16] blue
  output logic [1:0]       out_tuser,  // [0] was_clamped, [1] range_invalid
  // register writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int DW = hslc_pkg::DATA_W;
  localparam int F  = hslc_pkg::FRAC_BITS;
  localparam int Q  = hslc_pkg::QUOT_BITS;

  logic [DW-1:0] range_low_r;
  logic [DW-1:0] range_high_r;

  logic [DW:0]   num_full;
  logic [DW:0]   den_full;
  logic          inval_nxt;
  logic          clo_nxt;
  logic          chi_nxt;

  logic          s1_valid_r;
  logic [DW-1:0] num_r;
  logic [DW-1:0] den_r;
  logic          clo_r;
  logic          chi_r;
  logic          inval_r;
  logic          s1_ready;

  logic [hslc_pkg::DIVD_W-1:0] divd;
  hslc_pkg::div_word_t         s2_nxt;
  logic                        s2_valid_r;
  hslc_pkg::div_word_t         s2_word_r;
  logic                        s2_ready;

  logic                cv   [0:Q];
  logic                crdy [0:Q];
  hslc_pkg::div_word_t cw   [0:Q];

  // register writes, always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_low_r  <= hslc_pkg::RANGE_LOW_RST;
      range_high_r <= hslc_pkg::RANGE_HIGH_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == hslc_pkg::REG_RANGE_LOW) begin
        range_low_r <= cfg_data;
      end else if (cfg_index == hslc_pkg::REG_RANGE_HIGH) begin
        range_high_r <= cfg_data;
      end
    end
  end

  // offset and span against the configured bounds
  always_comb begin
    num_full  = {in_tdata[DW-1], in_tdata} - {range_low_r[DW-1], range_low_r};
    den_full  = {range_high_r[DW-1], range_high_r} - {range_low_r[DW-1], range_low_r};
    inval_nxt = ($signed(den_full) <= $signed((DW+1)'(0)));
    clo_nxt   = num_full[DW] && !inval_nxt;
    chi_nxt   = !num_full[DW] && (num_full > den_full) && !inval_nxt;
  end

  assign s1_ready  = !s2_valid_r || s2_ready;
  assign in_tready = !s1_valid_r || s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      num_r   <= num_full[DW-1:0];
      den_r   <= den_full[DW-1:0];
      clo_r   <= clo_nxt;
      chi_r   <= chi_nxt;
      inval_r <= inval_nxt;
    end
  end

  // dividend with the rounding half span folded in
  always_comb begin
    divd            = {1'b0, num_r, {F{1'b0}}} + hslc_pkg::DIVD_W'(den_r >> 1);
    s2_nxt.rem      = divd[hslc_pkg::DIVD_W-1 -: DW];
    s2_nxt.dbits    = divd[Q-1:0];
    s2_nxt.quot     = '0;
    s2_nxt.den      = den_r;
    s2_nxt.clamp_lo = clo_r;
    s2_nxt.clamp_hi = chi_r;
    s2_nxt.invalid  = inval_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && s1_valid_r) begin
      s2_word_r <= s2_nxt;
    end
  end

  // divider chain, one quotient bit per cell
  assign cv[0]    = s2_valid_r;
  assign cw[0]    = s2_word_r;
  assign s2_ready = crdy[0];

  for (genvar i = 0; i < Q; i++) begin : g_cell
    hslc_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (cv[i]),
      .up_ready (crdy[i]),
      .up_word  (cw[i]),
      .dn_valid (cv[i+1]),
      .dn_ready (crdy[i+1]),
      .dn_word  (cw[i+1])
    );
  end

  // hue to rgb and output register
  hslc_colour u_colour (
    .clk           (clk),
    .rst_n         (rst_n),
    .up_valid      (cv[Q]),
    .up_ready      (crdy[Q]),
    .up_word       (cw[Q]),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .red           (out_tdata[7:0]),
    .green         (out_tdata[15:8]),
    .blue          (out_tdata[23:16]),
    .was_clamped   (out_tuser[0]),
    .range_invalid (out_tuser[1])
  );

`ifndef SYNTHESIS
  // an empty output means nothing in the chain can be blocked
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with an empty output");

  // an empty or inverted range gives black and no clamp flag
  a_invalid_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1]) |-> (out_tdata == 24'd0 && !out_tuser[0]))
    else $error("invalid range word is not black");

  // a saturated value lands on one end of the map: black or pure red
  a_clamp_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tdata == 24'd0 || out_tdata == 24'h0000FF))
    else $error("clamped word not at a map end");

  // the drained pipeline must not produce a word from nothing
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    (!s1_valid_r && !s2_valid_r && !cv[Q] && !u_colour.c1_valid_r && !out_tvalid)
    |=> !out_tvalid)
    else $error("result appeared without an item in flight");
`endif

endmodule

`default_nettype wire

>>> hdl/hslc_div_cell.sv
// one cell of the divider chain: resolves one quotient bit per word
`default_nettype none

module hslc_div_cell (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              up_valid,
  output logic                   up_ready,
  input  wire hslc_pkg::div_word_t up_word,
  output logic                   dn_valid,
  input  wire logic              dn_ready,
  output hslc_pkg::div_word_t    dn_word
);

  logic                           valid_r;
  hslc_pkg::div_word_t            word_r;
  hslc_pkg::div_word_t            word_nxt;
  logic [hslc_pkg::DATA_W:0]      trial;
  logic                           take;

  // restoring step: bring in the next dividend bit, subtract if it fits
  always_comb begin
    trial    = {up_word.rem, up_word.dbits[hslc_pkg::QUOT_BITS-1]};
    take     = (trial >= {1'b0, up_word.den});
    word_nxt = up_word;
    if (take) begin
      word_nxt.rem = hslc_pkg::DATA_W'(trial - {1'b0, up_word.den});
    end else begin
      word_nxt.rem = trial[hslc_pkg::DATA_W-1:0];
    end
    word_nxt.dbits = {up_word.dbits[hslc_pkg::QUOT_BITS-2:0], 1'b0};
    word_nxt.quot  = {up_word.quot[hslc_pkg::QUOT_BITS-2:0], take};
  end

  // stage holds while the next one is full and stalled
  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      word_r <= word_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_word  = word_r;

endmodule

`default_nettype wire

>>> hdl/hslc_colour.sv
// hue sector and chroma products, then channel rounding and the output register
`default_nettype none

module hslc_colour (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           up_valid,
  output logic                                up_ready,
  input  wire hslc_pkg::div_word_t            up_word,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [hslc_pkg::COLOR_BITS-1:0]     red,
  output logic [hslc_pkg::COLOR_BITS-1:0]     green,
  output logic [hslc_pkg::COLOR_BITS-1:0]     blue,
  output logic                                was_clamped,
  output logic                                range_invalid
);

  localparam int F = hslc_pkg::FRAC_BITS;
  localparam int C = hslc_pkg::COLOR_BITS;

  typedef enum logic [2:0] {
    SEC_RED_YEL,
    SEC_YEL_GRN,
    SEC_GRN_CYN,
    SEC_CYN_BLU,
    SEC_BLU_MAG,
    SEC_MAG_RED
  } sector_t;

  logic [F:0]     t;
  logic [F+2:0]   hue;
  logic [F:0]     h;
  logic [F:0]     h_dist;
  logic [2*F+1:0] x_full;

  logic                              c1_valid_r;
  logic [F:0]                        t_r;
  logic [hslc_pkg::CHAN_IN_W-1:0]    x_r;
  sector_t                           sec_r;
  logic                              clamp_r;
  logic                              inval_r;
  logic                              c1_ready;
  logic                              c2_ready;

  logic [C-1:0] ch_c;
  logic [C-1:0] ch_x;
  logic [C-1:0] red_nxt;
  logic [C-1:0] green_nxt;
  logic [C-1:0] blue_nxt;

  logic         o_valid_r;
  logic [C-1:0] red_r;
  logic [C-1:0] green_r;
  logic [C-1:0] blue_r;
  logic         clamp_o_r;
  logic         inval_o_r;

  // saturated fraction, hue sector and secondary component
  always_comb begin
    if (up_word.invalid || up_word.clamp_lo) begin
      t = '0;
    end else if (up_word.clamp_hi || (up_word.quot > hslc_pkg::T_ONE)) begin
      t = hslc_pkg::T_ONE;
    end else begin
      t = up_word.quot;
    end
    hue = {hslc_pkg::T_ONE - t, 2'b00};
    h   = hue[F:0];
    if (h >= hslc_pkg::T_ONE) begin
      h_dist = h - hslc_pkg::T_ONE;
    end else begin
      h_dist = hslc_pkg::T_ONE - h;
    end
    x_full = t * (hslc_pkg::T_ONE - h_dist);
  end

  assign c2_ready = !o_valid_r || out_ready;
  assign c1_ready = !c1_valid_r || c2_ready;
  assign up_ready = c1_ready;

  // product stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_valid_r <= 1'b0;
    end else if (c1_ready) begin
      c1_valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (c1_ready && up_valid) begin
      t_r     <= t;
      x_r     <= x_full[hslc_pkg::CHAN_IN_W-1:0];
      sec_r   <= sector_t'(hue[F+2:F]);
      clamp_r <= (up_word.clamp_lo || up_word.clamp_hi) && !up_word.invalid;
      inval_r <= up_word.invalid;
    end
  end

  // round both components and route them by sector
  always_comb begin
    ch_c = hslc_pkg::to_channel({t_r, {F{1'b0}}});
    ch_x = hslc_pkg::to_channel(x_r);
    case (sec_r)
      SEC_RED_YEL: begin
        red_nxt = ch_c; green_nxt = ch_x; blue_nxt = '0;
      end
      SEC_YEL_GRN: begin
        red_nxt = ch_x; green_nxt = ch_c; blue_nxt = '0;
      end
      SEC_GRN_CYN: begin
        red_nxt = '0; green_nxt = ch_c; blue_nxt = ch_x;
      end
      SEC_CYN_BLU: begin
        red_nxt = '0; green_nxt = ch_x; blue_nxt = ch_c;
      end
      SEC_BLU_MAG: begin
        red_nxt = ch_x; green_nxt = '0; blue_nxt = ch_c;
      end
      default: begin
        red_nxt = ch_c; green_nxt = '0; blue_nxt = ch_x;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if (c2_ready) begin
      o_valid_r <= c1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (c2_ready && c1_valid_r) begin
      red_r     <= red_nxt;
      green_r   <= green_nxt;
      blue_r    <= blue_nxt;
      clamp_o_r <= clamp_r;
      inval_o_r <= inval_r;
    end
  end

  assign out_valid     = o_valid_r;
  assign red           = red_r;
  assign green         = green_r;
  assign blue          = blue_r;
  assign was_clamped   = clamp_o_r;
  assign range_invalid = inval_o_r;

endmodule

`default_nettype wire
